// ----- rtl/pfc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_pkg
// shared types, constants and helpers of the posit format converter
// ----------------------------------------------------------------------------

package pfc_pkg;

  // format limits
  localparam int MaxWidth    = 32;
  localparam int MaxExpWidth = 4;

  // field widths
  localparam int SizeW    = 6;                         // size registers
  localparam int EsW      = 3;                         // exponent size registers
  localparam int CfgDataW = 6;                         // widest register
  localparam int CfgIdxW  = 2;                         // four registers
  localparam int StatusW  = 3;
  localparam int IdxW     = $clog2(MaxWidth);          // bit position in a word
  localparam int KW       = $clog2(MaxWidth) + 1;      // signed regime
  localparam int ExW      = KW + MaxExpWidth + 1;      // signed total exponent

  localparam int QueueDepth = 2;

  // reset values of the registers
  localparam logic [SizeW-1:0] InSizeRst     = SizeW'(16);
  localparam logic [EsW-1:0]   InExpSizeRst  = EsW'(1);
  localparam logic [SizeW-1:0] OutSizeRst    = SizeW'(32);
  localparam logic [EsW-1:0]   OutExpSizeRst = EsW'(2);

  typedef enum logic [CfgIdxW-1:0] {
    REG_IN_SIZE      = 2'd0,
    REG_IN_EXP_SIZE  = 2'd1,
    REG_OUT_SIZE     = 2'd2,
    REG_OUT_EXP_SIZE = 2'd3
  } reg_idx_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 3'd0,
    ST_PARAMS  = 3'd1,
    ST_BADENC  = 3'd2,
    ST_NOEXP   = 3'd3,
    ST_SPECIAL = 3'd4
  } status_e;

  // what the back end has to do with a decoded word
  typedef enum logic [2:0] {
    KIND_PACK    = 3'd0,
    KIND_PARAMS  = 3'd1,
    KIND_BADENC  = 3'd2,
    KIND_ZERO    = 3'd3,
    KIND_NAR     = 3'd4,
    KIND_SAT_MIN = 3'd5,
    KIND_SAT_MAX = 3'd6
  } kind_e;

  typedef struct packed {
    logic [SizeW-1:0] in_size;
    logic [EsW-1:0]   in_exp_size;
    logic [SizeW-1:0] out_size;
    logic [EsW-1:0]   out_exp_size;
  } cfg_t;

  typedef struct packed {
    kind_e                   kind;
    logic                    neg;
    logic signed [KW-1:0]    k2;     // output regime
    logic [MaxExpWidth-1:0]  e2;     // output exponent
    logic [IdxW-1:0]         fsrc;   // input fraction width
    logic [MaxWidth-1:0]     frac;   // input fraction bits
  } dec_t;

  // low n bits set; n above MaxWidth gives all ones
  function automatic logic [MaxWidth-1:0] width_mask(input logic [SizeW-1:0] n);
    logic [MaxWidth:0] t;
    t = (MaxWidth+1)'(1) << n;
    t = t - (MaxWidth+1)'(1);
    return t[MaxWidth-1:0];
  endfunction

endpackage

// ----- rtl/pfc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_front
// takes input words, removes the sign and decodes regime, exponent, fraction
// ----------------------------------------------------------------------------

module pfc_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pfc_pkg::cfg_t                  cfg_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [pfc_pkg::MaxWidth-1:0]   in_word_i,
  output logic                           dec_valid_o,
  input  logic                           dec_ready_i,
  output pfc_pkg::dec_t                  dec_o
);

  // input stage: magnitude and sign
  logic                          valid_q, valid_d;
  logic [pfc_pkg::MaxWidth-1:0]  mag_q, mag_d;
  logic                          neg_q, neg_d;

  logic [pfc_pkg::MaxWidth-1:0]  in_mask, masked, sign_word;

  always_comb begin
    in_mask   = pfc_pkg::width_mask(cfg_i.in_size);
    masked    = in_word_i & in_mask;
    sign_word = masked >> (cfg_i.in_size - pfc_pkg::SizeW'(1));
    neg_d     = sign_word[0];
    mag_d     = neg_d ? ((~masked + pfc_pkg::MaxWidth'(1)) & in_mask) : masked;
  end

  assign in_ready_o = !valid_q || dec_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      mag_q <= mag_d;
      neg_q <= neg_d;
    end
  end

  // decode stage
  logic [pfc_pkg::SizeW-1:0]          n1, n2;
  logic [pfc_pkg::EsW-1:0]            es1, es2;
  logic                               params_bad, widen, narrow;
  logic [pfc_pkg::MaxWidth-1:0]       top_word, rv_word, run_word, e_word, f_word;
  logic [pfc_pkg::MaxWidth-1:0]       es2_mask;
  logic                               rv, found, bad;
  logic [pfc_pkg::IdxW-1:0]           idx, fs;
  logic signed [pfc_pkg::ExW-1:0]     n1x, n2x, idxx, kx, ex, k2x, ex_e;
  logic                               sat_min, sat_max;
  pfc_pkg::dec_t                      dec;

  always_comb begin
    n1  = cfg_i.in_size;
    n2  = cfg_i.out_size;
    es1 = cfg_i.in_exp_size;
    es2 = cfg_i.out_exp_size;

    params_bad = (n1 < pfc_pkg::SizeW'(3)) || (n1 > pfc_pkg::SizeW'(pfc_pkg::MaxWidth)) ||
                 (n2 < pfc_pkg::SizeW'(3)) || (n2 > pfc_pkg::SizeW'(pfc_pkg::MaxWidth)) ||
                 (es1 > pfc_pkg::EsW'(pfc_pkg::MaxExpWidth)) ||
                 (es2 > pfc_pkg::EsW'(pfc_pkg::MaxExpWidth));
    widen  = (n2 >= n1) && (es2 >= es1);
    narrow = !widen && (n2 <= n1) && (es2 <= es1);

    top_word = pfc_pkg::MaxWidth'(1) << (n1 - pfc_pkg::SizeW'(1));

    // regime run: first bit below the regime head that differs from it
    rv_word  = mag_q >> (n1 - pfc_pkg::SizeW'(2));
    rv       = rv_word[0];
    run_word = (rv ? ~mag_q : mag_q) & pfc_pkg::width_mask(n1 - pfc_pkg::SizeW'(2));
    found    = 1'b0;
    idx      = '0;
    for (int i = 0; i < pfc_pkg::MaxWidth; i++) begin
      if (run_word[i]) begin
        found = 1'b1;
        idx   = pfc_pkg::IdxW'(i);
      end
    end
    bad = !found || (idx == '0) || (idx < pfc_pkg::IdxW'(es1));

    n1x  = signed'(pfc_pkg::ExW'(n1));
    n2x  = signed'(pfc_pkg::ExW'(n2));
    idxx = signed'(pfc_pkg::ExW'(idx));
    fs   = idx - pfc_pkg::IdxW'(es1);
    e_word = (mag_q >> fs) & pfc_pkg::width_mask(pfc_pkg::SizeW'(es1));
    f_word = mag_q & pfc_pkg::width_mask(pfc_pkg::SizeW'(fs));
    kx = rv ? (n1x - signed'(pfc_pkg::ExW'(3)) - idxx)
            : (idxx - n1x + signed'(pfc_pkg::ExW'(2)));

    // magnitude one is minpos
    if (mag_q == pfc_pkg::MaxWidth'(1)) begin
      kx     = signed'(pfc_pkg::ExW'(2)) - n1x;
      e_word = '0;
      fs     = '0;
      f_word = '0;
    end

    ex   = (kx <<< es1) + signed'(pfc_pkg::ExW'(e_word[pfc_pkg::MaxExpWidth-1:0]));
    k2x  = ex >>> es2;
    es2_mask = pfc_pkg::width_mask(pfc_pkg::SizeW'(es2));
    ex_e = ex & signed'(pfc_pkg::ExW'(es2_mask[pfc_pkg::MaxExpWidth-1:0]));

    sat_min = narrow && (k2x <= (signed'(pfc_pkg::ExW'(2)) - n2x));
    sat_max = narrow && (k2x >= (n2x - signed'(pfc_pkg::ExW'(2))));

    dec.neg  = neg_q;
    dec.k2   = k2x[pfc_pkg::KW-1:0];
    dec.e2   = ex_e[pfc_pkg::MaxExpWidth-1:0];
    dec.fsrc = fs;
    dec.frac = f_word;

    priority if (params_bad || (!widen && !narrow)) begin
      dec.kind = pfc_pkg::KIND_PARAMS;
    end else if (mag_q == '0) begin
      dec.kind = pfc_pkg::KIND_ZERO;
    end else if (mag_q == top_word) begin
      dec.kind = pfc_pkg::KIND_NAR;
    end else if ((mag_q != pfc_pkg::MaxWidth'(1)) && bad) begin
      dec.kind = pfc_pkg::KIND_BADENC;
    end else if (sat_min) begin
      dec.kind = pfc_pkg::KIND_SAT_MIN;
    end else if (sat_max) begin
      dec.kind = pfc_pkg::KIND_SAT_MAX;
    end else begin
      dec.kind = pfc_pkg::KIND_PACK;
    end
  end

  assign dec_valid_o = valid_q;
  assign dec_o       = dec;

endmodule

// ----- rtl/pfc_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_queue
// short queue of decoded words between front and back end
// ----------------------------------------------------------------------------

module pfc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  pfc_pkg::dec_t  push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output pfc_pkg::dec_t  pop_data_o
);

  localparam int PtrW = (pfc_pkg::QueueDepth > 1) ? $clog2(pfc_pkg::QueueDepth) : 1;
  localparam int CntW = $clog2(pfc_pkg::QueueDepth + 1);

  pfc_pkg::dec_t   mem_q [pfc_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(pfc_pkg::QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(pfc_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(pfc_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // fill level stays in range
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(pfc_pkg::QueueDepth))
    else $error("queue count out of range");

  // a word pushed into an empty queue is visible next cycle
  a_push_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 && push) |=> pop_valid_o)
    else $error("pushed word not visible");

  // a stalled head is not overwritten
  a_head_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_valid_o && !pop_ready_i) |=> $stable(pop_data_o))
    else $error("queue head changed while stalled");

endmodule

// ----- rtl/pfc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_back
// repacks a decoded word in the output format into the output register
// ----------------------------------------------------------------------------

module pfc_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pfc_pkg::cfg_t                 cfg_i,
  input  logic                          dec_valid_i,
  output logic                          dec_ready_o,
  input  pfc_pkg::dec_t                 dec_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [pfc_pkg::MaxWidth-1:0]  out_word_o,
  output pfc_pkg::status_e              out_status_o
);

  logic [pfc_pkg::SizeW-1:0]       n2, pos, run_len, fs2, fsrc;
  logic [pfc_pkg::EsW-1:0]         es2;
  logic signed [pfc_pkg::ExW-1:0]  kx, n2x, pos_raw, kc;
  logic [pfc_pkg::MaxWidth-1:0]    run_word, xr, e_field, f2, xp, x_pack, res_mag, res;
  logic [pfc_pkg::MaxWidth-1:0]    n2_mask, n2m1_mask;
  logic                            noexp, apply_neg;
  pfc_pkg::status_e                st_pack, status;

  always_comb begin
    n2  = cfg_i.out_size;
    es2 = cfg_i.out_exp_size;
    kx  = {{(pfc_pkg::ExW-pfc_pkg::KW){dec_i.k2[pfc_pkg::KW-1]}}, dec_i.k2};
    n2x = signed'(pfc_pkg::ExW'(n2));
    n2_mask   = pfc_pkg::width_mask(n2);
    n2m1_mask = pfc_pkg::width_mask(n2 - pfc_pkg::SizeW'(1));

    // regime field position
    pos_raw = (kx < 0) ? (n2x + kx - signed'(pfc_pkg::ExW'(2)))
                       : (n2x - kx - signed'(pfc_pkg::ExW'(3)));
    pos = (pos_raw < 0) ? '0 : pos_raw[pfc_pkg::SizeW-1:0];
    kc  = (kx > signed'(pfc_pkg::ExW'(pfc_pkg::MaxWidth - 3)))
          ? signed'(pfc_pkg::ExW'(pfc_pkg::MaxWidth - 3)) : kx;
    run_len  = kc[pfc_pkg::SizeW-1:0] + pfc_pkg::SizeW'(2);
    run_word = pfc_pkg::width_mask(run_len) & ~pfc_pkg::MaxWidth'(1);
    xr = ((kx < 0) ? (pfc_pkg::MaxWidth'(1) << pos) : (run_word << pos)) & n2m1_mask;

    // exponent and fraction behind the regime
    noexp   = pos < pfc_pkg::SizeW'(es2);
    fs2     = pos - pfc_pkg::SizeW'(es2);
    fsrc    = pfc_pkg::SizeW'(dec_i.fsrc);
    e_field = (pfc_pkg::MaxWidth'(dec_i.e2) & pfc_pkg::width_mask(pfc_pkg::SizeW'(es2)))
              << fs2;
    f2 = (fs2 >= fsrc) ? (dec_i.frac << (fs2 - fsrc)) : (dec_i.frac >> (fsrc - fs2));
    xp = xr | e_field | (f2 & pfc_pkg::width_mask(fs2));
    x_pack  = noexp ? xr : xp;
    st_pack = noexp ? pfc_pkg::ST_NOEXP : pfc_pkg::ST_OK;

    unique case (dec_i.kind)
      pfc_pkg::KIND_PACK: begin
        res_mag = x_pack;  apply_neg = dec_i.neg; status = st_pack;
      end
      pfc_pkg::KIND_SAT_MIN: begin
        res_mag = pfc_pkg::MaxWidth'(1); apply_neg = dec_i.neg; status = pfc_pkg::ST_OK;
      end
      pfc_pkg::KIND_SAT_MAX: begin
        res_mag = n2m1_mask; apply_neg = dec_i.neg; status = pfc_pkg::ST_OK;
      end
      pfc_pkg::KIND_NAR: begin
        res_mag = n2_mask ^ n2m1_mask; apply_neg = 1'b0; status = pfc_pkg::ST_SPECIAL;
      end
      pfc_pkg::KIND_ZERO: begin
        res_mag = '0; apply_neg = 1'b0; status = pfc_pkg::ST_SPECIAL;
      end
      pfc_pkg::KIND_BADENC: begin
        res_mag = '0; apply_neg = 1'b0; status = pfc_pkg::ST_BADENC;
      end
      pfc_pkg::KIND_PARAMS: begin
        res_mag = '0; apply_neg = 1'b0; status = pfc_pkg::ST_PARAMS;
      end
      default: begin
        res_mag = '0; apply_neg = 1'b0; status = pfc_pkg::ST_PARAMS;
      end
    endcase

    res = (apply_neg ? (~res_mag + pfc_pkg::MaxWidth'(1)) : res_mag) & n2_mask;
  end

  // output register
  logic                          out_valid_q, out_valid_d;
  logic [pfc_pkg::MaxWidth-1:0]  out_word_q;
  pfc_pkg::status_e              out_status_q;

  assign dec_ready_o = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (dec_ready_o) begin
      out_valid_d = dec_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dec_ready_o && dec_valid_i) begin
      out_word_q   <= res;
      out_status_q <= status;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_word_o   = out_word_q;
  assign out_status_o = out_status_q;

  // zero and NaR carry at most one set bit
  a_special_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == pfc_pkg::ST_SPECIAL) |-> ($countones(out_word_q) <= 1))
    else $error("special result has more than one bit set");

  // error results carry a zero word
  a_error_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q == pfc_pkg::ST_PARAMS ||
                     out_status_q == pfc_pkg::ST_BADENC)) |-> (out_word_q == '0))
    else $error("error result with nonzero word");

endmodule

// ----- rtl/posit_format_convert.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// posit_format_convert
// re-encodes posit words from the configured input format to the output format
// ----------------------------------------------------------------------------
// path: input stage, queue, output register; throughput: one word per cycle
//   if not stalled; the decode stage and the output register hold one word each
//   and the queue two, so the back end stalls on its own
// reset: format registers return to 16/1 in and 32/2 out, all stages empty
// ----------------------------------------------------------------------------

module posit_format_convert (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration writes
  input  logic                                cfg_we_i,
  input  logic [pfc_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [pfc_pkg::CfgDataW-1:0]        cfg_wdata_i,
  // input words
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [31:0]                         s_axis_tdata,   // posit_in[31:0]
  // result words
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [31:0]                         m_axis_tdata,   // posit_out[31:0]
  output logic [pfc_pkg::StatusW-1:0]         m_axis_tuser    // status[2:0]
);

  // format registers
  logic [pfc_pkg::SizeW-1:0] in_size_q, out_size_q;
  logic [pfc_pkg::EsW-1:0]   in_exp_size_q, out_exp_size_q;
  pfc_pkg::cfg_t             cfg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_size_q      <= pfc_pkg::InSizeRst;
      in_exp_size_q  <= pfc_pkg::InExpSizeRst;
      out_size_q     <= pfc_pkg::OutSizeRst;
      out_exp_size_q <= pfc_pkg::OutExpSizeRst;
    end else if (cfg_we_i) begin
      unique case (pfc_pkg::reg_idx_e'(cfg_idx_i))
        pfc_pkg::REG_IN_SIZE:      in_size_q      <= cfg_wdata_i[pfc_pkg::SizeW-1:0];
        pfc_pkg::REG_IN_EXP_SIZE:  in_exp_size_q  <= cfg_wdata_i[pfc_pkg::EsW-1:0];
        pfc_pkg::REG_OUT_SIZE:     out_size_q     <= cfg_wdata_i[pfc_pkg::SizeW-1:0];
        pfc_pkg::REG_OUT_EXP_SIZE: out_exp_size_q <= cfg_wdata_i[pfc_pkg::EsW-1:0];
        default: ;
      endcase
    end
  end

  // the user changes formats only while the block is idle (unenforced); all stages read them live
  assign cfg.in_size      = in_size_q;
  assign cfg.in_exp_size  = in_exp_size_q;
  assign cfg.out_size     = out_size_q;
  assign cfg.out_exp_size = out_exp_size_q;

  // front end: sign removal, then regime run detect and field extraction
  logic          fr_valid, fr_ready;
  pfc_pkg::dec_t fr_dec;

  pfc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_word_i   (s_axis_tdata),
    .dec_valid_o (fr_valid),
    .dec_ready_i (fr_ready),
    .dec_o       (fr_dec)
  );

  // decoded words wait here while the output side stalls
  logic          bk_valid, bk_ready;
  pfc_pkg::dec_t bk_dec;

  pfc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_dec),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_data_o   (bk_dec)
  );

  // back end: regime, exponent and fraction repacking, sign restore
  pfc_pkg::status_e bk_status;

  pfc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .dec_valid_i  (bk_valid),
    .dec_ready_o  (bk_ready),
    .dec_i        (bk_dec),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_word_o   (m_axis_tdata),
    .out_status_o (bk_status)
  );

  assign m_axis_tuser = bk_status;

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// checks posit_format_convert word by word against its own format converter
// ----------------------------------------------------------------------------
// a directed table comes first: zero and NaR, minpos of both signs, maxpos,
// bad regimes, saturation when narrowing, no exponent room, parameter errors.
// after it come random formats, each loaded while the block is idle, with
// mostly well-formed posits of random regime length. both stream sides idle
// and stall at random until the last third, and every result is checked in order.
// ----------------------------------------------------------------------------

module tb_top;

  // four format registers as written on the config port
  typedef struct packed {
    logic [5:0] in_sz;
    logic [5:0] in_es;
    logic [5:0] out_sz;
    logic [5:0] out_es;
  } fmt_t;

  // one converted word
  typedef struct {
    logic [31:0]      posit;
    pfc_pkg::status_e st;
  } conv_result_t;

  // one row of the directed table; want_* only used where typed is set
  typedef struct {
    fmt_t             fmt;
    logic [31:0]      word;
    bit               typed;
    logic [31:0]      want_out;
    pfc_pkg::status_e want_st;
  } stim_row_t;

  localparam fmt_t FMT_RST    = '{6'd16, 6'd1, 6'd32, 6'd2};  // format after reset
  localparam fmt_t FMT_WIDE16 = '{6'd16, 6'd4, 6'd32, 6'd4};
  localparam fmt_t FMT_SAME16 = '{6'd16, 6'd1, 6'd16, 6'd1};
  localparam fmt_t FMT_NARROW = '{6'd32, 6'd4, 6'd8,  6'd0};
  localparam fmt_t FMT_MIXED  = '{6'd8,  6'd2, 6'd16, 6'd1};
  localparam fmt_t FMT_TINY   = '{6'd2,  6'd0, 6'd0,  6'd0};  // sizes below range
  localparam fmt_t FMT_OVER   = '{6'd33, 6'd5, 6'd63, 6'd7};  // sizes and es above range
  localparam fmt_t FMT_MIN    = '{6'd3,  6'd0, 6'd3,  6'd0};

  localparam int RandomWords = 525;
  localparam int SettleCycles = 8;       // margin beyond the latency of the block

  logic clk = 1'b0;
  logic rst_ni = 1'b0;

  logic              cfg_we_i = 1'b0;
  pfc_pkg::reg_idx_e cfg_idx_i = pfc_pkg::REG_IN_SIZE;
  logic [5:0]        cfg_wdata_i = '0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;        // posit_in[31:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;             // posit_out[31:0]
  logic [2:0]  m_axis_tuser;             // status[2:0]

  // side information that travels with the word on the input side
  bit               row_typed_q = 1'b0;
  logic [31:0]      row_out_q = '0;
  pfc_pkg::status_e row_st_q = pfc_pkg::ST_OK;

  // format as the block holds it, tracked from the config port
  logic [5:0]  in_sz_q  = pfc_pkg::InSizeRst;
  logic [2:0]  in_es_q  = pfc_pkg::InExpSizeRst;
  logic [5:0]  out_sz_q = pfc_pkg::OutSizeRst;
  logic [2:0]  out_es_q = pfc_pkg::OutExpSizeRst;

  conv_result_t pending_results [$];
  int unsigned  words_sent = 0;
  int unsigned  results_seen = 0;
  int unsigned  fails = 0;
  int unsigned  send_idle_pct = 19;
  int unsigned  recv_idle_pct = 68;
  fmt_t         cur_fmt = FMT_RST;

  stim_row_t dir_rows [0:24] = '{
    // format after reset, 16/1 to 32/2
    '{FMT_RST, 32'h0000_0000, 1'b1, 32'h0000_0000, pfc_pkg::ST_SPECIAL},
    '{FMT_RST, 32'h0000_8000, 1'b1, 32'h8000_0000, pfc_pkg::ST_SPECIAL},
    '{FMT_RST, 32'hFFFF_0000, 1'b1, 32'h0000_0000, pfc_pkg::ST_SPECIAL},  // upper bits ignored
    '{FMT_RST, 32'h0000_0001, 1'b0, 32'h0, pfc_pkg::ST_OK},              // minpos
    '{FMT_RST, 32'h0000_FFFF, 1'b0, 32'h0, pfc_pkg::ST_OK},              // negative minpos
    '{FMT_RST, 32'h0000_7FFF, 1'b1, 32'h0000_0000, pfc_pkg::ST_BADENC},  // run hits bit 0
    '{FMT_RST, 32'h0000_7FFE, 1'b1, 32'h0000_0000, pfc_pkg::ST_BADENC},  // run hits bit 1
    '{FMT_RST, 32'h0000_4000, 1'b0, 32'h0, pfc_pkg::ST_OK},              // one
    '{FMT_RST, 32'hABCD_1234, 1'b0, 32'h0, pfc_pkg::ST_OK},
    '{FMT_RST, 32'h0000_0002, 1'b0, 32'h0, pfc_pkg::ST_OK},              // no fraction bits left
    // regime leaves fewer bits than the exponent needs
    '{FMT_WIDE16, 32'h0000_0004, 1'b1, 32'h0000_0000, pfc_pkg::ST_BADENC},
    // equal formats: minpos has no room for the exponent
    '{FMT_SAME16, 32'h0000_0001, 1'b1, 32'h0000_0001, pfc_pkg::ST_NOEXP},
    '{FMT_SAME16, 32'h0000_FFFF, 1'b1, 32'h0000_FFFF, pfc_pkg::ST_NOEXP},
    '{FMT_SAME16, 32'h0000_1234, 1'b0, 32'h0, pfc_pkg::ST_OK},
    // narrowing 32/4 to 8/0, saturation of both signs and NaR
    '{FMT_NARROW, 32'h7FF0_0000, 1'b1, 32'h0000_007F, pfc_pkg::ST_OK},
    '{FMT_NARROW, 32'h8010_0000, 1'b1, 32'h0000_0081, pfc_pkg::ST_OK},
    '{FMT_NARROW, 32'h0000_1000, 1'b1, 32'h0000_0001, pfc_pkg::ST_OK},
    '{FMT_NARROW, 32'hFFFF_F000, 1'b1, 32'h0000_00FF, pfc_pkg::ST_OK},
    '{FMT_NARROW, 32'h0000_0001, 1'b1, 32'h0000_0001, pfc_pkg::ST_OK},
    '{FMT_NARROW, 32'h8000_0000, 1'b1, 32'h0000_0080, pfc_pkg::ST_SPECIAL},
    '{FMT_NARROW, 32'h1234_5678, 1'b0, 32'h0, pfc_pkg::ST_OK},
    // parameter errors: mixed direction, sizes below and above range
    '{FMT_MIXED, 32'h0000_0055, 1'b1, 32'h0000_0000, pfc_pkg::ST_PARAMS},
    '{FMT_TINY,  32'h0000_0003, 1'b1, 32'h0000_0000, pfc_pkg::ST_PARAMS},
    '{FMT_OVER,  32'h0000_0040, 1'b1, 32'h0000_0000, pfc_pkg::ST_PARAMS},
    // smallest format
    '{FMT_MIN, 32'h0000_0003, 1'b0, 32'h0, pfc_pkg::ST_OK}
  };

  posit_format_convert dut (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // low n bits set, n from 0 to 32
  function automatic logic [31:0] low_bits(input int n);
    logic [63:0] t;
    t = (64'd1 << n) - 64'd1;
    return t[31:0];
  endfunction

  // expected conversion of one word under the tracked format
  function automatic conv_result_t convert_posit(input logic [31:0] word);
    int n1, es1, n2, es2;
    int k, e, ex, fs, idx, dv, k2, e2, pos, fo, kk;
    logic neg, widen, narrow, rv;
    logic [31:0] p, f, x;
    logic [63:0] f2, rg;
    conv_result_t r;
    n1 = int'(in_sz_q);
    es1 = int'(in_es_q);
    n2 = int'(out_sz_q);
    es2 = int'(out_es_q);
    r.posit = '0;
    r.st = pfc_pkg::ST_PARAMS;
    if (n1 < 3 || n1 > pfc_pkg::MaxWidth || n2 < 3 || n2 > pfc_pkg::MaxWidth ||
        es1 > pfc_pkg::MaxExpWidth || es2 > pfc_pkg::MaxExpWidth) begin
      return r;
    end
    // equal formats count as widening
    widen = (n2 >= n1) && (es2 >= es1);
    narrow = !widen && (n2 <= n1) && (es2 <= es1);
    if (!widen && !narrow) begin
      return r;
    end

    // strip the sign by two's complement
    p = word & low_bits(n1);
    neg = p[n1-1];
    if (neg) begin
      p = (-p) & low_bits(n1);
    end
    if (p == 0 || p == (32'd1 << (n1 - 1))) begin
      r.posit = (p == 0) ? 32'd0 : (32'd1 << (n2 - 1));
      r.st = pfc_pkg::ST_SPECIAL;
      return r;
    end

    // minpos keeps its regime whatever the sign was
    if (p == 32'd1) begin
      k = 2 - n1;
      e = 0;
      fs = 0;
      f = '0;
    end else begin
      rv = p[n1-2];
      idx = n1 - 3;
      while (idx >= 0 && p[idx] == rv) idx--;
      if (idx <= 0 || idx < es1) begin
        r.st = pfc_pkg::ST_BADENC;
        return r;
      end
      k = rv ? (n1 - 3 - idx) : (idx - n1 + 2);
      fs = idx - es1;
      e = int'((p >> fs) & low_bits(es1));
      f = p & low_bits(fs);
    end

    // split the total exponent again, regime rounded toward minus infinity
    ex = k * (1 << es1) + e;
    dv = 1 << es2;
    k2 = (ex >= 0) ? ex / dv : -((-ex + dv - 1) / dv);
    e2 = ex - k2 * dv;

    r.st = pfc_pkg::ST_OK;
    if (narrow && k2 <= 2 - n2) begin
      x = 32'd1;
    end else if (narrow && k2 >= n2 - 2) begin
      x = (32'd1 << (n2 - 1)) - 32'd1;
    end else begin
      if (k2 < 0) begin
        pos = n2 + k2 - 2;
        if (pos < 0) pos = 0;
        x = 32'd1 << pos;
      end else begin
        pos = n2 - k2 - 3;
        if (pos < 0) pos = 0;
        kk = (k2 + 2 > 31) ? 29 : k2;
        rg = ((64'd1 << (kk + 2)) - 64'd2) << pos;
        x = rg[31:0];
      end
      x &= low_bits(n2 - 1);
      if (pos < es2) begin
        // regime bits alone
        r.st = pfc_pkg::ST_NOEXP;
      end else begin
        fo = pos - es2;
        x |= (32'(e2) & low_bits(es2)) << fo;
        // fraction truncated when it shrinks, zero filled when it grows
        if (fo >= fs) f2 = {32'd0, f} << (fo - fs);
        else f2 = {32'd0, f >> (fs - fo)};
        x |= f2[31:0] & low_bits(fo);
      end
    end
    if (neg) x = -x;
    r.posit = x & low_bits(n2);
    return r;
  endfunction

  // random format: mostly a legal direction, sometimes anything the port allows
  function automatic fmt_t pick_format();
    int a, b, ea, eb;
    fmt_t f;
    if ($urandom_range(0, 99) < 20) begin
      f.in_sz = 6'($urandom());
      f.in_es = 6'($urandom());
      f.out_sz = 6'($urandom());
      f.out_es = 6'($urandom());
      return f;
    end
    a = $urandom_range(3, pfc_pkg::MaxWidth);
    b = $urandom_range(3, pfc_pkg::MaxWidth);
    if ($urandom_range(0, 3) == 0) a = 3;
    if ($urandom_range(0, 3) == 0) b = pfc_pkg::MaxWidth;
    ea = $urandom_range(0, pfc_pkg::MaxExpWidth);
    eb = $urandom_range(0, pfc_pkg::MaxExpWidth);
    if ($urandom_range(0, 1)) begin
      // widening
      f = '{6'((a < b) ? a : b), 6'((ea < eb) ? ea : eb),
            6'((a < b) ? b : a), 6'((ea < eb) ? eb : ea)};
    end else begin
      // narrowing
      f = '{6'((a < b) ? b : a), 6'((ea < eb) ? eb : ea),
            6'((a < b) ? a : b), 6'((ea < eb) ? ea : eb)};
    end
    return f;
  endfunction

  // random input word, biased toward well-formed regimes of n bits
  function automatic logic [31:0] pick_word(input int n);
    logic [31:0] w, m;
    int run, i;
    logic rv;
    w = $urandom();
    if (n < 3 || n > pfc_pkg::MaxWidth) return w;
    m = low_bits(n);
    case ($urandom_range(0, 9))
      0: w = (w & ~m) | ($urandom_range(0, 1) ? (32'd1 << (n - 1)) : 32'd0);
      1: w = (w & ~m) | ($urandom_range(0, 1) ? 32'd1 : m);
      2: w = (w & ~m) | ($urandom_range(0, 1) ? (m >> 1) : ((32'd1 << (n - 1)) | 32'd1));
      3, 4, 5, 6: begin
        // regime run of chosen length, then its end bit, then random bits
        run = $urandom_range(1, n - 1);
        rv = 1'($urandom());
        for (i = 0; i < run && n - 2 - i >= 0; i++) w[n-2-i] = rv;
        if (n - 2 - run >= 0) w[n-2-run] = ~rv;
        w[n-1] = 1'b0;
        if ($urandom_range(0, 1)) w = (w & ~m) | ((-w) & m);
      end
      default: ;
    endcase
    return w;
  endfunction

  // write all four registers, one per cycle
  task automatic load_format(input fmt_t f);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= pfc_pkg::REG_IN_SIZE;
    cfg_wdata_i <= f.in_sz;
    @(posedge clk);
    cfg_idx_i <= pfc_pkg::REG_IN_EXP_SIZE;
    cfg_wdata_i <= f.in_es;
    @(posedge clk);
    cfg_idx_i <= pfc_pkg::REG_OUT_SIZE;
    cfg_wdata_i <= f.out_sz;
    @(posedge clk);
    cfg_idx_i <= pfc_pkg::REG_OUT_EXP_SIZE;
    cfg_wdata_i <= f.out_es;
    @(posedge clk);
    cfg_we_i <= 1'b0;
    cur_fmt = f;
  endtask

  // hold the input side until every word sent has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (results_seen < words_sent) @(posedge clk);
  endtask

  // offer one word, with random idle cycles ahead of it
  task automatic send_word(input logic [31:0] w, input bit typed,
                           input logic [31:0] t_out, input pfc_pkg::status_e t_st);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= w;
    row_typed_q <= typed;
    row_out_q <= t_out;
    row_st_q <= t_st;
    do @(posedge clk); while (!s_axis_tready);
    words_sent++;
  endtask

  // config tracking, result checking, expectation capture and output stalls
  always @(posedge clk) begin
    conv_result_t want;
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pfc_pkg::REG_IN_SIZE:      in_sz_q <= cfg_wdata_i;
          pfc_pkg::REG_IN_EXP_SIZE:  in_es_q <= cfg_wdata_i[2:0];
          pfc_pkg::REG_OUT_SIZE:     out_sz_q <= cfg_wdata_i;
          pfc_pkg::REG_OUT_EXP_SIZE: out_es_q <= cfg_wdata_i[2:0];
          default: ;
        endcase
      end
      // check before capture so a word never meets its own expectation
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("unexpected result word: posit_out %h status %0d",
                 m_axis_tdata, m_axis_tuser);
          fails++;
        end else begin
          want = pending_results.pop_front();
          if (m_axis_tdata !== want.posit) begin
            $error("posit_out: expected %h, actual %h", want.posit, m_axis_tdata);
            fails++;
          end
          if (m_axis_tuser !== want.st) begin
            $error("status: expected %0d, actual %0d", want.st, m_axis_tuser);
            fails++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (row_typed_q) pending_results.push_back('{row_out_q, row_st_q});
        else pending_results.push_back(convert_posit(s_axis_tdata));
      end
    end
  end

  initial begin
    int i, nw, random_words;
    fmt_t f;
    random_words = 0;
    repeat (11) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // directed table, reloading the format wherever a row asks for another
    for (i = 0; i < 25; i++) begin
      if (dir_rows[i].fmt != cur_fmt) begin
        wait_drained();
        load_format(dir_rows[i].fmt);
      end
      send_word(dir_rows[i].word, dir_rows[i].typed,
                dir_rows[i].want_out, dir_rows[i].want_st);
    end

    // random phases; each phase drains the block fully before the next format
    while (random_words < RandomWords) begin
      f = pick_format();
      wait_drained();
      load_format(f);
      nw = $urandom_range(10, 40);
      for (i = 0; i < nw && random_words < RandomWords; i++) begin
        // sender idles lightly first, then heavily, then neither side idles
        if (random_words < RandomWords / 3) begin
          send_idle_pct = 19;
          recv_idle_pct = 68;
        end else if (random_words < 2 * RandomWords / 3) begin
          send_idle_pct = 68;
          recv_idle_pct = 19;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        send_word(pick_word(int'(cur_fmt.in_sz)), 1'b0, 32'h0, pfc_pkg::ST_OK);
        random_words++;
      end
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected result words never arrived", pending_results.size());
      fails++;
    end
    if (fails == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // run limit, far above the slowest legal run
  initial begin
    #400000;
    $display("tb_top failed");
    $finish;
  end

endmodule

// ----- posit_format_convert.f -----
rtl/pfc_pkg.sv
rtl/pfc_front.sv
rtl/pfc_queue.sv
rtl/pfc_back.sv
rtl/posit_format_convert.sv
dv/tb_top.sv
